// ===== hdl/clock_with_single_button_set_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Clock with single button set - assertion macros
// Shared property forms for the clock unit checks.
// ---------------------------------------------------------------------------
`ifndef CLOCK_WITH_SINGLE_BUTTON_SET_UNIT_ASSERT_SVH
`define CLOCK_WITH_SINGLE_BUTTON_SET_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CWSBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CWSBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cwsbs_pkg.sv =====
// ---------------------------------------------------------------------------
// Clock with single button set - package
// Field types, opcodes, wrap limits and counter helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwsbs_pkg;

  typedef logic [1:0] opcode_t;
  typedef logic [4:0] hours_t;
  typedef logic [5:0] minutes_t;
  typedef logic [5:0] seconds_t;
  typedef logic [1:0] field_t;
  typedef logic [7:0] limit_t;

  localparam opcode_t OP_SECOND = 2'd0;
  localparam opcode_t OP_PRESS  = 2'd1;
  localparam opcode_t OP_SAMPLE = 2'd2;

  localparam field_t FIELD_SEC  = 2'd0;
  localparam field_t FIELD_MIN  = 2'd1;
  localparam field_t FIELD_HOUR = 2'd2;

  localparam limit_t   LIMIT_RESET = 8'h15;
  localparam seconds_t SEC_WRAP    = 6'd60;
  localparam minutes_t MIN_WRAP    = 6'd60;
  localparam hours_t   HOUR_WRAP   = 5'd24;

  function automatic seconds_t sec_inc(input seconds_t v);
    seconds_t n;
    n = v + 6'd1;
    return (n >= SEC_WRAP) ? 6'd0 : n;
  endfunction

  function automatic minutes_t min_inc(input minutes_t v);
    minutes_t n;
    n = v + 6'd1;
    return (n >= MIN_WRAP) ? 6'd0 : n;
  endfunction

  function automatic hours_t hour_inc(input hours_t v);
    hours_t n;
    n = v + 5'd1;
    return (n >= HOUR_WRAP) ? 5'd0 : n;
  endfunction

endpackage

// ===== hdl/cwsbs_item_if.sv =====
// ---------------------------------------------------------------------------
// Clock with single button set - item channel
// Valid/ready channel carrying one opcode and the button level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cwsbs_item_if;
  import cwsbs_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  logic    pin_pressed;

  modport source (output valid, output opcode, output pin_pressed, input ready);
  modport sink   (input valid, input opcode, input pin_pressed, output ready);
endinterface

// ===== hdl/cwsbs_result_if.sv =====
// ---------------------------------------------------------------------------
// Clock with single button set - result channel
// Valid/ready channel carrying the time, selection and change flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cwsbs_result_if;
  import cwsbs_pkg::*;

  logic     valid;
  logic     ready;
  hours_t   hours;
  minutes_t minutes;
  seconds_t seconds;
  field_t   selected_field;
  logic     display_changed;

  modport source (
    output valid, output hours, output minutes, output seconds,
    output selected_field, output display_changed, input ready
  );
  modport sink (
    input valid, input hours, input minutes, input seconds,
    input selected_field, input display_changed, output ready
  );
endinterface

// ===== hdl/clock_with_single_button_set_unit.sv =====
// ---------------------------------------------------------------------------
// Clock with single button set - top level
// 24-hour time of day with one-button field setting.
// ---------------------------------------------------------------------------
//   channel   dir   handshake      payload
//   item      in    valid/ready    opcode, pin_pressed
//   result    out   valid/ready    hours, minutes, seconds, selected_field,
//                                  display_changed
//   cfg       in    cfg_we         cfg_wdata (long press limit)
//
// One item per cycle unless the result stalls. State and the output register
// take the item's result in the same edge as its transfer. Reset clears time,
// selection and press timer, and reloads limit.
// item.ready is high while the output register is empty or being drained.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module clock_with_single_button_set_unit (
  input  logic                   clk,
  input  logic                   rst,
  cwsbs_item_if.sink             item,
  cwsbs_result_if.source         result,
  input  logic                   cfg_we,
  input  cwsbs_pkg::limit_t      cfg_wdata
);
  import cwsbs_pkg::*;

  limit_t   long_press_limit;
  seconds_t sec_count, sec_next;
  minutes_t min_count, min_next;
  hours_t   hour_count, hour_next;
  field_t   field_select, field_next;
  logic     press_armed, armed_next;
  limit_t   hold_count, hold_next;
  limit_t   hold_inc;
  logic     changed;
  logic     take;

  logic     res_valid;
  hours_t   res_hours;
  minutes_t res_minutes;
  seconds_t res_seconds;
  field_t   res_field;
  logic     res_changed;

  assign item.ready = !res_valid || result.ready;
  assign take       = item.valid && item.ready;

  always_comb begin
    sec_next   = sec_count;
    min_next   = min_count;
    hour_next  = hour_count;
    field_next = field_select;
    armed_next = press_armed;
    hold_next  = hold_count;
    hold_inc   = hold_count + 8'd1;
    changed    = 1'b0;
    case (item.opcode)
      OP_SECOND: begin
        sec_next = sec_inc(sec_count);
        if (sec_next == 6'd0) begin
          min_next = min_inc(min_count);
          if (min_next == 6'd0) begin
            hour_next = hour_inc(hour_count);
          end
        end
        changed = 1'b1;
      end
      OP_PRESS: begin
        armed_next = 1'b1;
      end
      OP_SAMPLE: begin
        if (press_armed) begin
          if (item.pin_pressed) begin
            hold_next = hold_inc;
            if (hold_inc > long_press_limit) begin
              field_next = (field_select >= FIELD_HOUR) ? FIELD_SEC : field_select + 2'd1;
              armed_next = 1'b0;
              hold_next  = 8'd0;
              changed    = 1'b1;
            end
          end else begin
            case (field_select)
              FIELD_SEC:  sec_next  = sec_inc(sec_count);
              FIELD_MIN:  min_next  = min_inc(min_count);
              FIELD_HOUR: hour_next = hour_inc(hour_count);
              default: ;
            endcase
            armed_next = 1'b0;
            hold_next  = 8'd0;
            changed    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_limit <= LIMIT_RESET;
      sec_count        <= '0;
      min_count        <= '0;
      hour_count       <= '0;
      field_select     <= FIELD_SEC;
      press_armed      <= 1'b0;
      hold_count       <= '0;
      res_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        long_press_limit <= cfg_wdata;
      end
      if (take) begin
        sec_count    <= sec_next;
        min_count    <= min_next;
        hour_count   <= hour_next;
        field_select <= field_next;
        press_armed  <= armed_next;
        hold_count   <= hold_next;
        res_valid    <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_hours   <= hour_next;
      res_minutes <= min_next;
      res_seconds <= sec_next;
      res_field   <= field_next;
      res_changed <= changed;
    end
  end

  assign result.valid           = res_valid;
  assign result.hours           = res_hours;
  assign result.minutes         = res_minutes;
  assign result.seconds         = res_seconds;
  assign result.selected_field  = res_field;
  assign result.display_changed = res_changed;

`include "clock_with_single_button_set_unit_assert.svh"

  `CWSBS_ASSERT_NOW(a_time_range, 1'b1,
    (sec_count < SEC_WRAP) && (min_count < MIN_WRAP) && (hour_count < HOUR_WRAP),
    "time counter out of range")
  `CWSBS_ASSERT_NOW(a_idle_timer, !press_armed, hold_count == 8'd0,
    "hold count nonzero while disarmed")
  `CWSBS_ASSERT_NOW(a_no_overrun, take, !(res_valid && !result.ready),
    "item taken while result is stalled")
  `CWSBS_ASSERT_NEXT(a_result_follows, take, res_valid,
    "no result after item transfer")

endmodule
